// ===== hdl/red_eye_region_scorer_defines.svh =====
// assertion macros shared by the red-eye scorer rtl
// no dependencies; expects clk and rst_n in the scope where a macro is used
`ifndef RED_EYE_REGION_SCORER_DEFINES_SVH
`define RED_EYE_REGION_SCORER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RERS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define RERS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rers_pkg.sv =====
// types, constants and helper functions for the red-eye region scorer
// no dependencies; imported by every other file of the block except the defines header
`default_nettype none

package rers_pkg;

  // pixel and rectangle geometry
  localparam int PIX_BITS        = 12;
  localparam int COORD_BITS      = 12;
  localparam int RECT_FIELD_BITS = 13;
  localparam int RECT_BITS       = 4 * RECT_FIELD_BITS;
  localparam int CHAN_BITS       = 8;

  // counters
  localparam int CNT_BITS = 25;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // red pixel thresholds
  localparam logic [CHAN_BITS-1:0] HUE_LO  = 8'd10;
  localparam logic [CHAN_BITS-1:0] HUE_HI  = 8'd170;
  localparam logic [CHAN_BITS-1:0] SAT_MIN = 8'd70;
  localparam logic [CHAN_BITS-1:0] VAL_MIN = 8'd70;

  // scores in q8
  localparam int Q8_BITS = 9;
  localparam logic [Q8_BITS-1:0] Q8_ONE   = 9'd256;
  localparam logic [Q8_BITS-1:0] CAP_LOC  = 9'd204;
  localparam logic [Q8_BITS-1:0] CAP_NLOC = 9'd102;

  // localized test: 1000*re*tf > 3500*rf*te + 18*te*tf
  localparam int K_LOC_BITS = 10;
  localparam int K_LOC      = 1000;
  localparam int K_FACE     = 3500;
  localparam int K_OFS      = 18;
  localparam int PROD_BITS  = 2 * CNT_BITS;
  localparam int LHS_BITS   = PROD_BITS + K_LOC_BITS;
  localparam int RHS_BITS   = PROD_BITS + 13;

  // ratio > 0.08 as 25*re > 2*te
  localparam int HIGH_BITS = CNT_BITS + 5;
  localparam int HIGH_NUM  = 25;
  localparam int HIGH_DEN  = 2;

  // linear score floor(3200*re/te), 8 quotient bits
  localparam int K_LIN        = 3200;
  localparam int NUM_BITS     = CNT_BITS + 12;
  localparam int DIV_BITS     = 8;
  localparam int DIV_IDX_BITS = $clog2(DIV_BITS);

  // floor(n/5) for n <= 1024 as (n*52429) >> 18
  localparam int FIVE_IN_BITS   = Q8_BITS + 2;
  localparam int FIVE_RECIP     = 52429;
  localparam int FIVE_SHIFT     = 18;
  localparam int FIVE_PROD_BITS = FIVE_IN_BITS + 16;

  // apb port
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_LSB   = 3;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - REG_IDX_LSB;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_FACE      = 2'd0,
    REG_LEFT_EYE  = 2'd1,
    REG_RIGHT_EYE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [RECT_FIELD_BITS-1:0] y1;
    logic [RECT_FIELD_BITS-1:0] x1;
    logic [RECT_FIELD_BITS-1:0] y0;
    logic [RECT_FIELD_BITS-1:0] x0;
  } rect_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_ACC,
    S_CMP,
    S_DIV,
    S_EYE,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {
    MUL_RE_TF,
    MUL_RF_TE,
    MUL_TE_TF
  } mul_sel_t;

  typedef enum logic {
    EYE_LEFT,
    EYE_RIGHT
  } eye_t;

  typedef struct packed {
    logic                    in_ready;
    mul_sel_t                mul_sel;
    logic                    mul_en;
    logic                    lhs_ld;
    logic                    rhs_ld;
    logic                    rhs_acc;
    logic                    cmp_ld;
    logic                    div_step;
    logic [DIV_IDX_BITS-1:0] div_bit;
    eye_t                    eye;
    logic                    eye_wr;
    logic                    out_load;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } sts_t;

  function automatic logic in_box(input rect_t box,
                                  input logic [RECT_FIELD_BITS-1:0] x,
                                  input logic [RECT_FIELD_BITS-1:0] y);
    return (x >= box.x0) && (x < box.x1) && (y >= box.y0) && (y < box.y1);
  endfunction

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rers_if.sv =====
// valid/ready channel interfaces: pixel input and score result
// depends on rers_pkg
`default_nettype none

interface rers_pix_if;
  import rers_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIX_BITS-1:0]   pix_x;
  logic [PIX_BITS-1:0]   pix_y;
  logic [CHAN_BITS-1:0]  hue;
  logic [CHAN_BITS-1:0]  sat;
  logic [CHAN_BITS-1:0]  val;
  logic                  last_pixel;

  modport source (output valid, pix_x, pix_y, hue, sat, val, last_pixel, input ready);
  modport sink   (input valid, pix_x, pix_y, hue, sat, val, last_pixel, output ready);
endinterface

interface rers_score_if;
  import rers_pkg::*;

  logic               valid;
  logic               ready;
  logic [Q8_BITS-1:0] score_q8;
  logic               red_eye_found;
  logic [Q8_BITS-1:0] left_score_q8;
  logic [Q8_BITS-1:0] right_score_q8;

  modport source (output valid, score_q8, red_eye_found, left_score_q8, right_score_q8,
                  input ready);
  modport sink   (input valid, score_q8, red_eye_found, left_score_q8, right_score_q8,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/rers_cfg.sv =====
// apb register file holding the face and eye rectangles
// depends on rers_pkg
`default_nettype none

module rers_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rers_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [rers_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [rers_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output rers_pkg::rect_t                    face_rect,
  output rers_pkg::rect_t                    left_rect,
  output rers_pkg::rect_t                    right_rect
);
  import rers_pkg::*;

  rect_t face_r, face_nxt;
  rect_t left_r, left_nxt;
  rect_t right_r, right_nxt;
  logic [REG_IDX_BITS-1:0] idx;
  logic wr_en;
  rect_t wr_val;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_BITS-1:REG_IDX_LSB];
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_val = rect_t'(pwdata[RECT_BITS-1:0]);

  always_comb begin
    face_nxt  = face_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (wr_en) begin
      unique case (idx)
        REG_FACE:      face_nxt  = wr_val;
        REG_LEFT_EYE:  left_nxt  = wr_val;
        REG_RIGHT_EYE: right_nxt = wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_r  <= '0;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      face_r  <= face_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_FACE:      prdata = APB_DATA_BITS'(face_r);
      REG_LEFT_EYE:  prdata = APB_DATA_BITS'(left_r);
      REG_RIGHT_EYE: prdata = APB_DATA_BITS'(right_r);
      default:       prdata = '0;
    endcase
  end

  assign face_rect  = face_r;
  assign left_rect  = left_r;
  assign right_rect = right_r;

endmodule

`default_nettype wire

// ===== hdl/rers_ctrl.sv =====
// sequencer: pixel intake, per-eye scoring steps and result hand-off
// depends on rers_pkg and red_eye_region_scorer_defines.svh
`default_nettype none
`include "red_eye_region_scorer_defines.svh"

module rers_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  input  rers_pkg::sts_t sts,
  output rers_pkg::cmd_t cmd
);
  import rers_pkg::*;

  state_t state_r, state_nxt;
  eye_t eye_r, eye_nxt;
  logic [DIV_IDX_BITS-1:0] div_bit_r, div_bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      eye_r     <= EYE_LEFT;
      div_bit_r <= '0;
    end else begin
      state_r   <= state_nxt;
      eye_r     <= eye_nxt;
      div_bit_r <= div_bit_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    eye_nxt     = eye_r;
    div_bit_nxt = div_bit_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_RE_TF;
    cmd.eye      = eye_r;
    cmd.div_bit  = div_bit_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid && in_last) begin
          eye_nxt   = EYE_LEFT;
          state_nxt = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.mul_sel = MUL_RE_TF;
        cmd.mul_en  = 1'b1;
        state_nxt   = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_sel = MUL_RF_TE;
        cmd.mul_en  = 1'b1;
        cmd.lhs_ld  = 1'b1;
        state_nxt   = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.mul_sel = MUL_TE_TF;
        cmd.mul_en  = 1'b1;
        cmd.rhs_ld  = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.rhs_acc = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_ld  = 1'b1;
        div_bit_nxt = DIV_IDX_BITS'(DIV_BITS - 1);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_bit_r == '0) begin
          state_nxt = S_EYE;
        end else begin
          div_bit_nxt = div_bit_r - 1'b1;
        end
      end
      S_EYE: begin
        cmd.eye_wr = 1'b1;
        if (eye_r == EYE_LEFT) begin
          eye_nxt   = EYE_RIGHT;
          state_nxt = S_MUL_A;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // a last pixel closes intake until the frame result is handed off
  `RERS_ASSERT_NEXT(a_last_stops_intake, in_valid && cmd.in_ready && in_last, !cmd.in_ready, "intake open after last pixel")
  // the result register is loaded only when it can take a value
  `RERS_ASSERT_NOW(a_load_needs_slot, cmd.out_load, sts.slot_free, "result loaded into a full slot")
  // every division starts from the top quotient bit
  `RERS_ASSERT_NEXT(a_div_starts_top, state_r == S_CMP, div_bit_r == DIV_IDX_BITS'(DIV_BITS - 1) && state_r == S_DIV, "division did not start at top bit")

endmodule

`default_nettype wire

// ===== hdl/rers_dp.sv =====
// datapath: rectangle counters, shared multiplier, divider and result register
// depends on rers_pkg and red_eye_region_scorer_defines.svh
`default_nettype none
`include "red_eye_region_scorer_defines.svh"

module rers_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rers_pkg::cmd_t                 cmd,
  output rers_pkg::sts_t                 sts,
  input  logic                           pix_valid,
  input  logic [rers_pkg::PIX_BITS-1:0]  pix_x,
  input  logic [rers_pkg::PIX_BITS-1:0]  pix_y,
  input  logic [rers_pkg::CHAN_BITS-1:0] hue,
  input  logic [rers_pkg::CHAN_BITS-1:0] sat,
  input  logic [rers_pkg::CHAN_BITS-1:0] val,
  input  rers_pkg::rect_t                face_rect,
  input  rers_pkg::rect_t                left_rect,
  input  rers_pkg::rect_t                right_rect,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [rers_pkg::Q8_BITS-1:0]   score_q8,
  output logic                           red_eye_found,
  output logic [rers_pkg::Q8_BITS-1:0]   left_score_q8,
  output logic [rers_pkg::Q8_BITS-1:0]   right_score_q8
);
  import rers_pkg::*;

  // counters
  logic [CNT_BITS-1:0] face_red_r, face_red_nxt, face_tot_r, face_tot_nxt;
  logic [CNT_BITS-1:0] left_red_r, left_red_nxt, left_tot_r, left_tot_nxt;
  logic [CNT_BITS-1:0] right_red_r, right_red_nxt, right_tot_r, right_tot_nxt;
  logic [RECT_FIELD_BITS-1:0] xm, ym;
  logic pix_take, is_red, in_face, in_left, in_right;

  // scoring
  logic [CNT_BITS-1:0] eye_red, eye_tot, rf_eff, tf_eff, mul_a, mul_b;
  logic face_empty;
  logic [PROD_BITS-1:0] prod_r;
  logic [LHS_BITS-1:0] lhs_r;
  logic [RHS_BITS-1:0] rhs_r;
  logic [NUM_BITS-1:0] num_lin, div_sub, rem_r;
  logic [DIV_BITS-1:0] quo_r;
  logic loc_r, high_r, ovf_r, zero_r;
  logic [Q8_BITS-1:0] cap, quo_q8, lin_cap, eye_score;
  logic [Q8_BITS-1:0] left_score_r, right_score_r;

  // frame result
  logic both_one;
  logic [Q8_BITS-1:0] best, frame_score;
  logic [FIVE_IN_BITS-1:0] best_x4;
  logic [FIVE_PROD_BITS-1:0] fifth_prod;
  logic out_valid_r;
  logic [Q8_BITS-1:0] score_r, left_out_r, right_out_r;
  logic found_r;

  // pixel classification and rectangle hits
  assign pix_take = pix_valid && cmd.in_ready;
  assign xm       = RECT_FIELD_BITS'(pix_x[COORD_BITS-1:0]);
  assign ym       = RECT_FIELD_BITS'(pix_y[COORD_BITS-1:0]);
  assign is_red   = ((hue < HUE_LO) || (hue > HUE_HI)) && (sat > SAT_MIN) && (val > VAL_MIN);
  assign in_face  = in_box(face_rect, xm, ym);
  assign in_left  = in_box(left_rect, xm, ym);
  assign in_right = in_box(right_rect, xm, ym);

  always_comb begin
    face_red_nxt  = face_red_r;
    face_tot_nxt  = face_tot_r;
    left_red_nxt  = left_red_r;
    left_tot_nxt  = left_tot_r;
    right_red_nxt = right_red_r;
    right_tot_nxt = right_tot_r;
    priority if (cmd.out_load) begin
      face_red_nxt  = '0;
      face_tot_nxt  = '0;
      left_red_nxt  = '0;
      left_tot_nxt  = '0;
      right_red_nxt = '0;
      right_tot_nxt = '0;
    end else if (pix_take) begin
      if (in_face) begin
        face_tot_nxt = sat_inc(face_tot_r);
        if (is_red) face_red_nxt = sat_inc(face_red_r);
      end
      if (in_left) begin
        left_tot_nxt = sat_inc(left_tot_r);
        if (is_red) left_red_nxt = sat_inc(left_red_r);
      end
      if (in_right) begin
        right_tot_nxt = sat_inc(right_tot_r);
        if (is_red) right_red_nxt = sat_inc(right_red_r);
      end
    end else begin
      // no transaction: counters hold
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_red_r  <= '0;
      face_tot_r  <= '0;
      left_red_r  <= '0;
      left_tot_r  <= '0;
      right_red_r <= '0;
      right_tot_r <= '0;
    end else begin
      face_red_r  <= face_red_nxt;
      face_tot_r  <= face_tot_nxt;
      left_red_r  <= left_red_nxt;
      left_tot_r  <= left_tot_nxt;
      right_red_r <= right_red_nxt;
      right_tot_r <= right_tot_nxt;
    end
  end

  // operands of the eye being scored; an empty face drops out of the test
  assign eye_red    = (cmd.eye == EYE_RIGHT) ? right_red_r : left_red_r;
  assign eye_tot    = (cmd.eye == EYE_RIGHT) ? right_tot_r : left_tot_r;
  assign face_empty = (face_tot_r == '0);
  assign tf_eff     = face_empty ? CNT_BITS'(1) : face_tot_r;
  assign rf_eff     = face_empty ? '0 : face_red_r;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RE_TF: begin
        mul_a = eye_red;
        mul_b = tf_eff;
      end
      MUL_RF_TE: begin
        mul_a = rf_eff;
        mul_b = eye_tot;
      end
      MUL_TE_TF: begin
        mul_a = eye_tot;
        mul_b = tf_eff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign num_lin = NUM_BITS'(eye_red) * NUM_BITS'(K_LIN);
  assign div_sub = NUM_BITS'(eye_tot) << cmd.div_bit;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    if (cmd.lhs_ld) lhs_r <= LHS_BITS'(prod_r) * LHS_BITS'(K_LOC);
    if (cmd.rhs_ld) begin
      rhs_r <= RHS_BITS'(prod_r) * RHS_BITS'(K_FACE);
    end else if (cmd.rhs_acc) begin
      rhs_r <= rhs_r + RHS_BITS'(prod_r) * RHS_BITS'(K_OFS);
    end
    if (cmd.cmp_ld) begin
      loc_r  <= RHS_BITS'(lhs_r) > rhs_r;
      high_r <= (HIGH_BITS'(eye_red) * HIGH_BITS'(HIGH_NUM)) >
                (HIGH_BITS'(eye_tot) * HIGH_BITS'(HIGH_DEN));
      ovf_r  <= num_lin >= (NUM_BITS'(eye_tot) << DIV_BITS);
      zero_r <= (eye_tot == '0);
      rem_r  <= num_lin;
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= div_sub) begin
        rem_r <= rem_r - div_sub;
        quo_r[cmd.div_bit] <= 1'b1;
      end
    end
  end

  // eye score from the comparison flags and the quotient
  assign cap       = loc_r ? CAP_LOC : CAP_NLOC;
  assign quo_q8    = Q8_BITS'(quo_r);
  assign lin_cap   = (ovf_r || (quo_q8 >= cap)) ? cap : quo_q8;
  assign eye_score = zero_r ? '0 : ((high_r && loc_r) ? Q8_ONE : lin_cap);

  always_ff @(posedge clk) begin
    if (cmd.eye_wr) begin
      if (cmd.eye == EYE_RIGHT) right_score_r <= eye_score;
      else                      left_score_r  <= eye_score;
    end
  end

  // frame score: 4/5 of the better eye unless both are full
  assign both_one    = (left_score_r == Q8_ONE) && (right_score_r == Q8_ONE);
  assign best        = (left_score_r > right_score_r) ? left_score_r : right_score_r;
  assign best_x4     = FIVE_IN_BITS'(best) << 2;
  assign fifth_prod  = FIVE_PROD_BITS'(best_x4) * FIVE_PROD_BITS'(FIVE_RECIP);
  assign frame_score = both_one ? Q8_ONE : Q8_BITS'(fifth_prod >> FIVE_SHIFT);

  // result register
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      score_r     <= frame_score;
      found_r     <= (frame_score == Q8_ONE);
      left_out_r  <= left_score_r;
      right_out_r <= right_score_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign score_q8       = score_r;
  assign red_eye_found  = found_r;
  assign left_score_q8  = left_out_r;
  assign right_score_q8 = right_out_r;

  // red counts never pass their totals, saturation included
  `RERS_ASSERT_NOW(a_red_le_total, 1'b1,
                   face_red_r <= face_tot_r && left_red_r <= left_tot_r &&
                   right_red_r <= right_tot_r,
                   "red count above pixel count")
  // the frame hand-off leaves the three totals and the face red count cleared
  `RERS_ASSERT_NEXT(a_clear_on_load, cmd.out_load,
                    face_tot_r == '0 && left_tot_r == '0 && right_tot_r == '0 &&
                    face_red_r == '0,
                    "counters not cleared after frame")
  // a finished division leaves a remainder below the divisor
  `RERS_ASSERT_NOW(a_div_remainder, cmd.eye_wr && !ovf_r && !zero_r,
                   rem_r < NUM_BITS'(eye_tot),
                   "divider remainder not reduced")

endmodule

`default_nettype wire

// ===== hdl/red_eye_region_scorer.sv =====
// red_eye_region_scorer top level: apb registers, sequencer and datapath
// depends on rers_pkg, rers_if, rers_cfg, rers_ctrl, rers_dp
//
// usage
//   in_pix carries one hsv pixel per transaction with its column and row;
//   last_pixel marks the final pixel of a frame. out_score carries one
//   transaction per frame: frame score, found flag and both eye scores.
//   the apb port holds the face, left eye and right eye boxes (64-bit data,
//   registers at byte 0, 8, 16); write them only while the block is idle.
// intake and scoring
//   ordinary pixels are accepted one per cycle, back to back, while intake is
//   open; the six saturating counters update at the accepting edge. a last
//   pixel starts the scoring sequence: per eye five multiply/compare steps on
//   one shared 25x25 multiplier plus eight restoring divide steps and a write,
//   all with in_pix.ready low; then the result is loaded and intake opens
// reset
//   rst_n low at a clock edge clears the boxes, the counters, the sequencer
//   and the result valid
// stalls
//   a waiting result sits in the output register while pixels of the next
//   frame keep flowing; a following last pixel waits at the end of scoring
//   until the output register is free
`default_nettype none

module red_eye_region_scorer (
  input  logic                               clk,
  input  logic                               rst_n,
  rers_pix_if.sink                           in_pix,
  rers_score_if.source                       out_score,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rers_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [rers_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [rers_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import rers_pkg::*;

  rect_t face_rect, left_rect, right_rect;
  cmd_t  cmd;
  sts_t  sts;

  // box registers
  rers_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .face_rect  (face_rect),
    .left_rect  (left_rect),
    .right_rect (right_rect)
  );

  // sequencer owns intake and the scoring steps
  rers_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .in_last  (in_pix.last_pixel),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_pix.ready = cmd.in_ready;

  // counters, arithmetic and the result register
  rers_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .pix_valid      (in_pix.valid),
    .pix_x          (in_pix.pix_x),
    .pix_y          (in_pix.pix_y),
    .hue            (in_pix.hue),
    .sat            (in_pix.sat),
    .val            (in_pix.val),
    .face_rect      (face_rect),
    .left_rect      (left_rect),
    .right_rect     (right_rect),
    .out_ready      (out_score.ready),
    .out_valid      (out_score.valid),
    .score_q8       (out_score.score_q8),
    .red_eye_found  (out_score.red_eye_found),
    .left_score_q8  (out_score.left_score_q8),
    .right_score_q8 (out_score.right_score_q8)
  );

endmodule

`default_nettype wire
